>>> rtl/core/chtv_pkg.sv
// ---------------------------------------------------------------------------
// chtv_pkg: shared types and constants of the clock hand triangle generator
// Angle units, register map, hand codes and the words passed between parts.
// ---------------------------------------------------------------------------
package chtv_pkg;

  // defaults for the top level parameters
  localparam int SINE_FRAC_BITS_DEF = 16;
  localparam int COORD_BITS_DEF     = 12;

  // angles in tenths of a degree
  localparam int ANGLE_W      = 12;
  localparam int QIDX_W       = 10;
  localparam int FULL_TURN    = 3600;
  localparam int QUARTER_TURN = 900;
  localparam int HOUR_STEP    = 300;
  localparam int MIN_STEP     = 60;
  localparam int MIN_TO_HOUR  = 5;

  // input limits
  localparam int HOUR_MAX = 23;
  localparam int HALF_DAY = 12;
  localparam int MIN_MAX  = 59;

  // configuration reset values
  localparam logic [9:0] CENTER_X_RST = 10'd282;
  localparam logic [9:0] CENTER_Y_RST = 10'd614;
  localparam logic [7:0] SEC_LEN_RST  = 8'd110;
  localparam logic [7:0] MIN_LEN_RST  = 8'd90;
  localparam logic [7:0] HOUR_LEN_RST = 8'd60;
  localparam logic [5:0] BASE_W_RST   = 6'd10;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X   = 3'd0,
    REG_CENTER_Y   = 3'd1,
    REG_SEC_LEN    = 3'd2,
    REG_MIN_LEN    = 3'd3,
    REG_HOUR_LEN   = 3'd4,
    REG_BASE_WIDTH = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    HAND_HOUR   = 2'd0,
    HAND_MINUTE = 2'd1,
    HAND_SECOND = 2'd2
  } hand_kind_t;

  typedef struct packed {
    logic [9:0] center_x;
    logic [9:0] center_y;
    logic [7:0] sec_len;
    logic [7:0] min_len;
    logic [7:0] hour_len;
    logic [5:0] base_w;
  } cfg_t;

  // one queued time word: the three hand angles
  typedef struct packed {
    logic [ANGLE_W-1:0] hour_ang;
    logic [ANGLE_W-1:0] min_ang;
    logic [ANGLE_W-1:0] sec_ang;
  } angles_t;

endpackage

>>> rtl/core/chtv_front.sv
// ---------------------------------------------------------------------------
// chtv_front: input stage
// Takes a time word, clamps it and registers the three hand angles.
// ---------------------------------------------------------------------------
module chtv_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [4:0]        hour,
  input  logic [5:0]        minute,
  input  logic [5:0]        second,
  output logic              push,
  input  logic              push_ready,
  output chtv_pkg::angles_t push_angles
);
  import chtv_pkg::*;

  logic       front_valid;
  angles_t    front_angles;
  angles_t    ang_calc;
  logic [4:0] h_cl;
  logic [3:0] h12;
  logic [5:0] m_cl;
  logic [5:0] s_cl;

  // clamp and fold to twelve hours
  always_comb begin
    h_cl = (hour > 5'(HOUR_MAX)) ? 5'(HOUR_MAX) : hour;
    m_cl = (minute > 6'(MIN_MAX)) ? 6'(MIN_MAX) : minute;
    s_cl = (second > 6'(MIN_MAX)) ? 6'(MIN_MAX) : second;
    h12  = (h_cl >= 5'(HALF_DAY)) ? 4'(h_cl - 5'(HALF_DAY)) : h_cl[3:0];
    ang_calc.hour_ang = ANGLE_W'(h12) * ANGLE_W'(HOUR_STEP)
                      + ANGLE_W'(m_cl) * ANGLE_W'(MIN_TO_HOUR);
    ang_calc.min_ang  = ANGLE_W'(m_cl) * ANGLE_W'(MIN_STEP) + ANGLE_W'(s_cl);
    ang_calc.sec_ang  = ANGLE_W'(s_cl) * ANGLE_W'(MIN_STEP);
  end

  assign in_ready    = !front_valid || push_ready;
  assign push        = front_valid;
  assign push_angles = front_angles;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else if (in_ready) begin
      front_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      front_angles <= ang_calc;
    end
  end

endmodule

>>> rtl/core/chtv_fifo.sv
// ---------------------------------------------------------------------------
// chtv_fifo: two-entry queue
// Holds angle words between the input stage and the hand sequencer.
// ---------------------------------------------------------------------------
module chtv_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              push_ready,
  input  chtv_pkg::angles_t push_angles,
  output logic              pop_valid,
  input  logic              pop,
  output chtv_pkg::angles_t pop_angles
);
  import chtv_pkg::*;

  angles_t    mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_angles = mem[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop)  rd_ptr <= !rd_ptr;
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_angles;
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> pop_valid)
    else $error("queue popped while empty");

endmodule

>>> rtl/core/chtv_sine_rom.sv
// ---------------------------------------------------------------------------
// chtv_sine_rom: quarter-wave sine table
// sin of 0..90 degrees in tenths, rounded to SINE_FRAC_BITS fraction bits.
// Two read ports with registered data.
// ---------------------------------------------------------------------------
module chtv_sine_rom #(
  parameter int SINE_FRAC_BITS = chtv_pkg::SINE_FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [chtv_pkg::QIDX_W-1:0] addr_a,
  input  logic [chtv_pkg::QIDX_W-1:0] addr_b,
  output logic [SINE_FRAC_BITS:0]     data_a,
  output logic [SINE_FRAC_BITS:0]     data_b
);
  import chtv_pkg::*;

  localparam int          ENTRIES = QUARTER_TURN + 1;
  localparam longint      PI_Q30  = 64'd3373259426;
  localparam longint      ONE_Q30 = 64'd1 << 30;

  typedef logic [SINE_FRAC_BITS:0] rom_t [ENTRIES];

  // taylor series in Q30, seven terms after x
  function automatic longint quarter_sin_q30(input longint t);
    longint x;
    longint x2;
    longint term;
    longint prod;
    longint sum;
    x    = (t * PI_Q30 + 64'd900) / 64'd1800;
    x2   = (x * x) >>> 30;
    term = x;
    sum  = x;
    for (int k = 1; k <= 7; k++) begin
      prod = (term * x2) >>> 30;
      case (k)
        1:       term = prod / 64'd6;
        2:       term = prod / 64'd20;
        3:       term = prod / 64'd42;
        4:       term = prod / 64'd72;
        5:       term = prod / 64'd110;
        6:       term = prod / 64'd156;
        default: term = prod / 64'd210;
      endcase
      if (k % 2 == 1) sum = sum - term;
      else            sum = sum + term;
    end
    if (sum < 0)       sum = 0;
    if (sum > ONE_Q30) sum = ONE_Q30;
    return sum;
  endfunction

  function automatic rom_t build_rom();
    rom_t   r;
    longint v;
    for (int i = 0; i < ENTRIES; i++) begin
      v    = quarter_sin_q30(longint'(i));
      r[i] = (SINE_FRAC_BITS + 1)'((v + (64'd1 << (29 - SINE_FRAC_BITS)))
                                  >>> (30 - SINE_FRAC_BITS));
    end
    return r;
  endfunction

  localparam rom_t ROM = build_rom();

  // registered reads
  always_ff @(posedge clk) begin
    if (en) begin
      data_a <= ROM[addr_a];
      data_b <= ROM[addr_b];
    end
  end

endmodule

>>> rtl/core/chtv_back.sv
// ---------------------------------------------------------------------------
// chtv_back: hand sequencer and vertex pipeline
// Issues one hand a cycle from the queue head unless the output stalls:
// table lookup, multiply, round and offset from the center, output register.
// ---------------------------------------------------------------------------
module chtv_back #(
  parameter int SINE_FRAC_BITS = chtv_pkg::SINE_FRAC_BITS_DEF,
  parameter int COORD_BITS     = chtv_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  chtv_pkg::cfg_t               cfg,
  input  logic                         head_valid,
  input  chtv_pkg::angles_t            head_angles,
  output logic                         head_pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   hand_kind,
  output logic signed [COORD_BITS-1:0] tip_x,
  output logic signed [COORD_BITS-1:0] tip_y,
  output logic signed [COORD_BITS-1:0] base_one_x,
  output logic signed [COORD_BITS-1:0] base_one_y,
  output logic signed [COORD_BITS-1:0] base_two_x,
  output logic signed [COORD_BITS-1:0] base_two_y,
  output logic                         last_hand
);
  import chtv_pkg::*;

  localparam int SW    = SINE_FRAC_BITS + 2;   // signed sine
  localparam int PW    = SINE_FRAC_BITS + 11;  // signed product
  localparam int OFF_W = 10;                    // rounded pixel offset
  localparam int SUM_W = 18;

  typedef struct packed {
    logic              neg;
    logic [QIDX_W-1:0] idx;
  } rom_addr_t;

  // fold an angle to a quarter-wave index and a sign
  function automatic rom_addr_t fold(input logic [ANGLE_W-1:0] a_in);
    rom_addr_t          r;
    logic [ANGLE_W-1:0] a;
    logic [ANGLE_W-1:0] rem;
    logic [1:0]         q;
    a = (a_in >= ANGLE_W'(FULL_TURN)) ? a_in - ANGLE_W'(FULL_TURN) : a_in;
    if (a >= ANGLE_W'(3 * QUARTER_TURN))      q = 2'd3;
    else if (a >= ANGLE_W'(2 * QUARTER_TURN)) q = 2'd2;
    else if (a >= ANGLE_W'(QUARTER_TURN))     q = 2'd1;
    else                                      q = 2'd0;
    case (q)
      2'd0:    rem = a;
      2'd1:    rem = a - ANGLE_W'(QUARTER_TURN);
      2'd2:    rem = a - ANGLE_W'(2 * QUARTER_TURN);
      default: rem = a - ANGLE_W'(3 * QUARTER_TURN);
    endcase
    r.idx = q[0] ? QIDX_W'(ANGLE_W'(QUARTER_TURN) - rem) : QIDX_W'(rem);
    r.neg = q[1];
    return r;
  endfunction

  // divide by 2^sh, rounding half away from zero
  function automatic logic signed [OFF_W-1:0] round_away(
    input logic signed [PW-1:0] v, input int sh);
    logic [PW-1:0] mag;
    logic [PW-1:0] r;
    mag = v[PW-1] ? PW'(-v) : PW'(v);
    r   = (mag + (PW'(1) << (sh - 1))) >> sh;
    return v[PW-1] ? -OFF_W'(r) : OFF_W'(r);
  endfunction

  // base offset: a nonzero value above a tenth of a pixel never rounds to zero
  function automatic logic signed [OFF_W-1:0] base_offset(input logic signed [PW-1:0] v);
    logic signed [OFF_W-1:0] o;
    logic [PW-1:0]           mag;
    logic [PW+3:0]           mag10;
    o     = round_away(v, SINE_FRAC_BITS + 1);
    mag   = v[PW-1] ? PW'(-v) : PW'(v);
    mag10 = {mag, 3'b000} + {2'b00, mag, 1'b0};
    if (o == '0 && mag10 > ((PW + 4)'(1) << (SINE_FRAC_BITS + 1))) begin
      o = v[PW-1] ? -OFF_W'(1) : OFF_W'(1);
    end
    return o;
  endfunction

  function automatic logic [COORD_BITS-1:0] coord(
    input logic [9:0] c, input logic signed [OFF_W-1:0] o, input logic sub);
    logic signed [SUM_W-1:0] sum;
    sum = sub ? $signed(SUM_W'(c)) - SUM_W'(o) : $signed(SUM_W'(c)) + SUM_W'(o);
    return sum[COORD_BITS-1:0];
  endfunction

  logic                    advance;
  logic                    issue;
  hand_kind_t              hand_idx;
  logic [ANGLE_W-1:0]      ang_sel;
  logic [ANGLE_W-1:0]      ang_cos;
  rom_addr_t               addr_s;
  rom_addr_t               addr_c;
  logic [7:0]              len_sel;
  logic [5:0]              w_sel;
  logic [SINE_FRAC_BITS:0] mag_s;
  logic [SINE_FRAC_BITS:0] mag_c;

  // lookup stage registers
  logic                    s1_valid;
  hand_kind_t              s1_kind;
  logic                    s1_neg_s;
  logic                    s1_neg_c;
  logic [7:0]              s1_len;
  logic [5:0]              s1_w;
  logic signed [SW-1:0]    sin_v;
  logic signed [SW-1:0]    cos_v;

  // product stage registers
  logic                    s2_valid;
  hand_kind_t              s2_kind;
  logic signed [PW-1:0]    s2_tip_c;
  logic signed [PW-1:0]    s2_tip_s;
  logic signed [PW-1:0]    s2_bx;
  logic signed [PW-1:0]    s2_by;

  logic signed [OFF_W-1:0] ox;
  logic signed [OFF_W-1:0] oy;
  logic signed [OFF_W-1:0] oy_fix;
  logic signed [OFF_W-1:0] tx;
  logic signed [OFF_W-1:0] ty;

  assign advance  = !out_valid || out_ready;
  assign issue    = advance && head_valid;
  assign head_pop = issue && (hand_idx == HAND_SECOND);

  // per-hand angle, length and width
  always_comb begin
    case (hand_idx)
      HAND_HOUR: begin
        ang_sel = head_angles.hour_ang;
        len_sel = cfg.hour_len;
        w_sel   = cfg.base_w;
      end
      HAND_MINUTE: begin
        ang_sel = head_angles.min_ang;
        len_sel = cfg.min_len;
        w_sel   = (cfg.base_w >= 6'd2) ? cfg.base_w - 6'd2 : 6'd0;
      end
      default: begin
        ang_sel = head_angles.sec_ang;
        len_sel = cfg.sec_len;
        w_sel   = (cfg.base_w >= 6'd4) ? cfg.base_w - 6'd4 : 6'd0;
      end
    endcase
    // quarter turn ahead, wrapped within one turn
    ang_cos = (ang_sel >= ANGLE_W'(FULL_TURN - QUARTER_TURN))
            ? ang_sel - ANGLE_W'(FULL_TURN - QUARTER_TURN)
            : ang_sel + ANGLE_W'(QUARTER_TURN);
    addr_s  = fold(ang_sel);
    addr_c  = fold(ang_cos);
  end

  // hand counter
  always_ff @(posedge clk) begin
    if (rst) begin
      hand_idx <= HAND_HOUR;
    end else if (issue) begin
      unique case (hand_idx)
        HAND_HOUR:   hand_idx <= HAND_MINUTE;
        HAND_MINUTE: hand_idx <= HAND_SECOND;
        default:     hand_idx <= HAND_HOUR;
      endcase
    end
  end

  chtv_sine_rom #(
    .SINE_FRAC_BITS(SINE_FRAC_BITS)
  ) u_rom (
    .clk   (clk),
    .en    (advance),
    .addr_a(addr_s.idx),
    .addr_b(addr_c.idx),
    .data_a(mag_s),
    .data_b(mag_c)
  );

  // pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= issue;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
  end

  assign sin_v = s1_neg_s ? -$signed({1'b0, mag_s}) : $signed({1'b0, mag_s});
  assign cos_v = s1_neg_c ? -$signed({1'b0, mag_c}) : $signed({1'b0, mag_c});

  // lookup and product stages
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_kind  <= hand_idx;
      s1_neg_s <= addr_s.neg;
      s1_neg_c <= addr_c.neg;
      s1_len   <= len_sel;
      s1_w     <= w_sel;
      s2_kind  <= s1_kind;
      s2_tip_c <= PW'(cos_v) * PW'($signed({1'b0, s1_len}));
      s2_tip_s <= PW'(sin_v) * PW'($signed({1'b0, s1_len}));
      s2_bx    <= -(PW'(sin_v) * PW'($signed({1'b0, s1_w})));
      s2_by    <= PW'(cos_v) * PW'($signed({1'b0, s1_w}));
    end
  end

  // rounding of the tip and base offsets
  always_comb begin
    tx     = round_away(s2_tip_c, SINE_FRAC_BITS);
    ty     = round_away(s2_tip_s, SINE_FRAC_BITS);
    ox     = base_offset(s2_bx);
    oy     = base_offset(s2_by);
    oy_fix = (ox == '0 && oy == '0) ? OFF_W'(1) : oy;
  end

  // output register
  always_ff @(posedge clk) begin
    if (advance) begin
      hand_kind  <= s2_kind;
      last_hand  <= (s2_kind == HAND_SECOND);
      tip_x      <= coord(cfg.center_x, tx, 1'b0);
      tip_y      <= coord(cfg.center_y, ty, 1'b0);
      base_one_x <= coord(cfg.center_x, ox, 1'b0);
      base_one_y <= coord(cfg.center_y, oy_fix, 1'b0);
      base_two_x <= coord(cfg.center_x, ox, 1'b1);
      base_two_y <= coord(cfg.center_y, oy_fix, 1'b1);
    end
  end

  a_last_on_second: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_hand == (hand_kind == HAND_SECOND)))
    else $error("last_hand does not match the second hand");

  a_pop_after_second: assert property (@(posedge clk) disable iff (rst)
    head_pop |-> (hand_idx == HAND_SECOND) && head_valid)
    else $error("queue word released before its last hand");

  a_hand_order: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && advance && s2_kind == HAND_MINUTE) |-> (hand_idx != HAND_MINUTE))
    else $error("hand order broken in the pipeline");

endmodule

>>> rtl/core/clock_hand_triangle_vertices_top.sv
// ---------------------------------------------------------------------------
// clock_hand_triangle_vertices_top: clock hand triangle generator
// One time of day in, three hand triangles out (hour, minute, second).
// ---------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+----------------------------------------
//  in      | in_valid / in_ready  | hour, minute, second
//  out     | out_valid / out_ready| hand_kind, tip, base_one, base_two, last
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  The sequencer issues one hand per cycle while the output is not stalled;
//  that rate is set by the single hand pipeline and its two table ports. A
//  word passes the input register, queue, lookup, product and output stages.
//  Reset restores the register defaults; the table is constant, no fill
//  pass. A two-word queue lets input keep flowing while the output stalls.
// ---------------------------------------------------------------------------
module clock_hand_triangle_vertices_top #(
  parameter int SINE_FRAC_BITS = chtv_pkg::SINE_FRAC_BITS_DEF,
  parameter int COORD_BITS     = chtv_pkg::COORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [chtv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [chtv_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [4:0]                      hour,
  input  logic [5:0]                      minute,
  input  logic [5:0]                      second,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      hand_kind,
  output logic signed [COORD_BITS-1:0]    tip_x,
  output logic signed [COORD_BITS-1:0]    tip_y,
  output logic signed [COORD_BITS-1:0]    base_one_x,
  output logic signed [COORD_BITS-1:0]    base_one_y,
  output logic signed [COORD_BITS-1:0]    base_two_x,
  output logic signed [COORD_BITS-1:0]    base_two_y,
  output logic                            last_hand
);
  import chtv_pkg::*;

  cfg_t    cfg;
  logic    push;
  logic    push_ready;
  angles_t push_angles;
  logic    head_valid;
  logic    head_pop;
  angles_t head_angles;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.center_x <= CENTER_X_RST;
      cfg.center_y <= CENTER_Y_RST;
      cfg.sec_len  <= SEC_LEN_RST;
      cfg.min_len  <= MIN_LEN_RST;
      cfg.hour_len <= HOUR_LEN_RST;
      cfg.base_w   <= BASE_W_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_CENTER_X:   cfg.center_x <= cfg_data[9:0];
        REG_CENTER_Y:   cfg.center_y <= cfg_data[9:0];
        REG_SEC_LEN:    cfg.sec_len  <= cfg_data[7:0];
        REG_MIN_LEN:    cfg.min_len  <= cfg_data[7:0];
        REG_HOUR_LEN:   cfg.hour_len <= cfg_data[7:0];
        REG_BASE_WIDTH: cfg.base_w   <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  chtv_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .hour       (hour),
    .minute     (minute),
    .second     (second),
    .push       (push),
    .push_ready (push_ready),
    .push_angles(push_angles)
  );

  chtv_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .push_angles(push_angles),
    .pop_valid  (head_valid),
    .pop        (head_pop),
    .pop_angles (head_angles)
  );

  chtv_back #(
    .SINE_FRAC_BITS(SINE_FRAC_BITS),
    .COORD_BITS    (COORD_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head_angles(head_angles),
    .head_pop   (head_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .hand_kind  (hand_kind),
    .tip_x      (tip_x),
    .tip_y      (tip_y),
    .base_one_x (base_one_x),
    .base_one_y (base_one_y),
    .base_two_x (base_two_x),
    .base_two_y (base_two_y),
    .last_hand  (last_hand)
  );

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: clock hand triangle generator
// Drives time words with random idle gaps and register writes, stalls the
// results at random, predicts the three hand triangles of each accepted word
// from an in-bench sine series, checks each result field by field in order.
// ---------------------------------------------------------------------------
module testbench;
  import chtv_pkg::*;

  localparam int FRAC = SINE_FRAC_BITS_DEF;
  localparam int CW = COORD_BITS_DEF;
  localparam longint unsigned PI_Q30 = 64'd3373259426;
  localparam longint ONE_Q30 = 64'sd1 << 30;
  localparam int DRAIN_CYCLES = 12;
  localparam int CYCLE_LIMIT = 200000;
  localparam int QUIET_LO = 1500;
  localparam int QUIET_HI = 3200;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  typedef struct {
    hand_kind_t kind;
    logic [CW-1:0] tx, ty, b1x, b1y, b2x, b2y;
    logic last;
  } triangle_t;

  typedef struct {
    int h, m, s;
    bit typed;
    int tx, ty, b1x, b1y, b2x, b2y;
  } time_row_t;

  logic clk, rst;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic in_valid, in_ready;
  logic [4:0] hour;
  logic [5:0] minute, second;
  logic out_valid, out_ready;
  logic [1:0] hand_kind;
  logic signed [CW-1:0] tip_x, tip_y, base_one_x, base_one_y, base_two_x, base_two_y;
  logic last_hand;

  // shadow of the register file
  logic [9:0] sh_cx, sh_cy;
  logic [7:0] sh_sec_len, sh_min_len, sh_hour_len;
  logic [5:0] sh_base_w;

  triangle_t triangle_q[$];
  int errors = 0;
  int cyc = 0;

  clock_hand_triangle_vertices_top u_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .hour(hour), .minute(minute), .second(second),
    .out_valid(out_valid), .out_ready(out_ready),
    .hand_kind(hand_kind), .tip_x(tip_x), .tip_y(tip_y),
    .base_one_x(base_one_x), .base_one_y(base_one_y),
    .base_two_x(base_two_x), .base_two_y(base_two_y),
    .last_hand(last_hand)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // idle decision, with a quiet window where nobody idles
  function automatic bit take_gap();
    if (cyc >= QUIET_LO && cyc < QUIET_HI) return 1'b0;
    return $urandom_range(0, 99) < 23;
  endfunction

  // sine over the first quadrant in Q30, series of eight terms
  function automatic longint quarter_sine(int unsigned t);
    longint unsigned x, x2, term;
    longint sum;
    x = (longint'(t) * PI_Q30 + 64'd900) / 64'd1800;
    x2 = (x * x) >> 30;
    term = x;
    sum = longint'(x);
    for (longint unsigned k = 1; k <= 7; k++) begin
      term = ((term * x2) >> 30) / ((2 * k) * (2 * k + 1));
      if (k[0]) sum -= longint'(term);
      else sum += longint'(term);
    end
    if (sum < 0) sum = 0;
    if (sum > ONE_Q30) sum = ONE_Q30;
    return sum;
  endfunction

  // sine of an angle in tenths of a degree with FRAC fraction bits
  function automatic longint sine_tenths(int unsigned a);
    int unsigned q, r;
    longint v, mg;
    a = a % FULL_TURN;
    q = a / QUARTER_TURN;
    r = a % QUARTER_TURN;
    v = q[0] ? quarter_sine(QUARTER_TURN - r) : quarter_sine(r);
    mg = (v + (64'sd1 << (29 - FRAC))) >>> (30 - FRAC);
    return (q >= 2) ? -mg : mg;
  endfunction

  function automatic longint round_away(longint v, int sh);
    longint unsigned mag;
    longint r;
    mag = (v < 0) ? longint'(-v) : v;
    r = longint'((mag + (64'd1 << (sh - 1))) >> sh);
    return (v < 0) ? -r : r;
  endfunction

  // base offset: tiny but visible offsets are pushed to one pixel
  function automatic longint base_offset(longint v);
    longint o;
    longint unsigned mag;
    o = round_away(v, FRAC + 1);
    mag = (v < 0) ? longint'(-v) : v;
    if (o == 0 && mag * 10 > (64'd1 << (FRAC + 1))) o = (v > 0) ? 1 : -1;
    return o;
  endfunction

  function automatic triangle_t hand_triangle(hand_kind_t k, int unsigned ang,
                                              longint len, longint w);
    triangle_t t;
    longint sn, cs, cx, cy, ox, oy;
    if (w < 0) w = 0;
    sn = sine_tenths(ang);
    cs = sine_tenths(ang + QUARTER_TURN);
    cx = longint'(sh_cx);
    cy = longint'(sh_cy);
    ox = base_offset(-sn * w);
    oy = base_offset(cs * w);
    if (ox == 0 && oy == 0) oy = 1;
    t.kind = k;
    t.tx = CW'(cx + round_away(len * cs, FRAC));
    t.ty = CW'(cy + round_away(len * sn, FRAC));
    t.b1x = CW'(cx + ox);
    t.b1y = CW'(cy + oy);
    t.b2x = CW'(cx - ox);
    t.b2y = CW'(cy - oy);
    t.last = (k == HAND_SECOND);
    return t;
  endfunction

  // expected triangles of one accepted time word
  task automatic predict_triangles(time_row_t row);
    int unsigned h, m, s;
    longint w;
    triangle_t t;
    h = (row.h > HOUR_MAX) ? HOUR_MAX : row.h;
    m = (row.m > MIN_MAX) ? MIN_MAX : row.m;
    s = (row.s > MIN_MAX) ? MIN_MAX : row.s;
    w = longint'(sh_base_w);
    t = hand_triangle(HAND_HOUR, (h % HALF_DAY) * HOUR_STEP + m * MIN_TO_HOUR,
                      longint'(sh_hour_len), w);
    if (row.typed) begin
      t.tx = CW'(row.tx); t.ty = CW'(row.ty);
      t.b1x = CW'(row.b1x); t.b1y = CW'(row.b1y);
      t.b2x = CW'(row.b2x); t.b2y = CW'(row.b2y);
    end
    triangle_q.push_back(t);
    triangle_q.push_back(hand_triangle(HAND_MINUTE, m * MIN_STEP + s,
                                       longint'(sh_min_len), w - 2));
    triangle_q.push_back(hand_triangle(HAND_SECOND, s * MIN_STEP,
                                       longint'(sh_sec_len), w - 4));
  endtask

  // send one time word, called and returning at a falling edge
  task automatic send_time(time_row_t row);
    while (take_gap()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    hour <= row.h[4:0];
    minute <= row.m[5:0];
    second <= row.s[5:0];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_triangles(row);
    @(negedge clk);
  endtask

  // one register write; the caller lowers cfg_valid after a burst
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_CENTER_X:   sh_cx = d;
      REG_CENTER_Y:   sh_cy = d;
      REG_SEC_LEN:    sh_sec_len = d[7:0];
      REG_MIN_LEN:    sh_min_len = d[7:0];
      REG_HOUR_LEN:   sh_hour_len = d[7:0];
      REG_BASE_WIDTH: sh_base_w = d[5:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // wait for every expected word, let the pipeline settle
  task automatic drain();
    while (triangle_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic load_regs(logic [9:0] cx, logic [9:0] cy, logic [9:0] sl,
                           logic [9:0] ml, logic [9:0] hl, logic [9:0] bw);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_SEC_LEN, sl);
    write_reg(REG_MIN_LEN, ml);
    write_reg(REG_HOUR_LEN, hl);
    write_reg(REG_BASE_WIDTH, bw);
    write_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_A : REG_SPARE_B,
              CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // random time words, mostly in range with some raw field values
  task automatic random_times(int n);
    time_row_t row;
    for (int i = 0; i < n; i++) begin
      row = '{default: 0};
      if ($urandom_range(0, 9) == 0) begin
        row.h = $urandom_range(0, 31);
        row.m = $urandom_range(0, 63);
        row.s = $urandom_range(0, 63);
      end else begin
        row.h = $urandom_range(0, HOUR_MAX);
        row.m = $urandom_range(0, MIN_MAX);
        row.s = $urandom_range(0, MIN_MAX);
      end
      send_time(row);
    end
  endtask

  function automatic bit check_field(string name, logic [CW-1:0] e, logic [CW-1:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch expected %0d actual %0d", $time, name,
               $signed(e), $signed(a));
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // result word checker
  always @(posedge clk) begin
    triangle_t t;
    bit bad;
    if (!rst && out_valid && out_ready) begin
      if (triangle_q.size() == 0) begin
        $display("%0t: unexpected result word, hand %0d", $time, hand_kind);
        errors++;
      end else begin
        t = triangle_q.pop_front();
        bad = check_field("hand_kind", CW'(t.kind), CW'(hand_kind));
        bad |= check_field("tip_x", t.tx, tip_x);
        bad |= check_field("tip_y", t.ty, tip_y);
        bad |= check_field("base_one_x", t.b1x, base_one_x);
        bad |= check_field("base_one_y", t.b1y, base_one_y);
        bad |= check_field("base_two_x", t.b2x, base_two_x);
        bad |= check_field("base_two_y", t.b2y, base_two_y);
        bad |= check_field("last_hand", CW'(t.last), CW'(last_hand));
        if (bad) errors++;
      end
    end
  end

  // output back-pressure, held low until reset is released
  always @(negedge clk) begin
    out_ready <= (rst !== 1'b0) ? 1'b0 : !take_gap();
  end

  // cycle counter and run limit
  always @(posedge clk) begin
    cyc++;
    if (cyc > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  time_row_t directed[] = '{
    '{0, 0, 0, 1, 342, 614, 282, 619, 282, 609},
    '{3, 0, 0, 1, 282, 674, 277, 614, 287, 614},
    '{6, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{9, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{12, 0, 0, 1, 342, 614, 282, 619, 282, 609},
    '{23, 59, 59, 0, 0, 0, 0, 0, 0, 0},
    '{31, 63, 63, 0, 0, 0, 0, 0, 0, 0},
    '{24, 0, 60, 0, 0, 0, 0, 0, 0, 0},
    '{0, 63, 0, 0, 0, 0, 0, 0, 0, 0},
    '{11, 30, 45, 0, 0, 0, 0, 0, 0, 0},
    '{1, 30, 15, 0, 0, 0, 0, 0, 0, 0},
    '{21, 42, 21, 0, 0, 0, 0, 0, 0, 0},
    '{10, 21, 42, 0, 0, 0, 0, 0, 0, 0},
    '{31, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{5, 7, 1, 0, 0, 0, 0, 0, 0, 0},
    '{7, 22, 37, 0, 0, 0, 0, 0, 0, 0},
    '{18, 45, 30, 0, 0, 0, 0, 0, 0, 0},
    '{2, 59, 0, 0, 0, 0, 0, 0, 0, 0}
  };

  // main sequence
  initial begin
    rst <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_index <= REG_CENTER_X;
    cfg_data <= '0;
    in_valid <= 1'b0;
    hour <= '0;
    minute <= '0;
    second <= '0;
    sh_cx = CENTER_X_RST;
    sh_cy = CENTER_Y_RST;
    sh_sec_len = SEC_LEN_RST;
    sh_min_len = MIN_LEN_RST;
    sh_hour_len = HOUR_LEN_RST;
    sh_base_w = BASE_W_RST;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed words at reset values
    foreach (directed[i]) send_time(directed[i]);
    in_valid <= 1'b0;
    drain();

    // largest values, with upper data bits set to check masking
    load_regs(10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF);
    random_times(15);
    in_valid <= 1'b0;
    drain();

    // all zero: no length, base width saturates on the minute and second hands
    load_regs(10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0);
    random_times(15);
    in_valid <= 1'b0;
    drain();

    // narrowest base that saturates no hand: one pixel pushes and the zero fallback
    load_regs(10'd5, 10'd1000, 10'd3, 10'd255, 10'd1, 10'd4);
    random_times(25);
    in_valid <= 1'b0;
    drain();

    // random settings, mostly narrow bases
    for (int p = 0; p < 8; p++) begin
      load_regs(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                CFG_DATA_W'($urandom),
                ($urandom_range(0, 1) != 0) ? CFG_DATA_W'($urandom_range(0, 7))
                                            : CFG_DATA_W'($urandom));
      random_times(50);
      in_valid <= 1'b0;
      drain();
    end

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
